@@ hdl/pcmmix_pkg.sv @@
// Shared types and constants of the two-stream PCM16 mixer.
// No dependencies; every module of the mixer imports this package.

package pcmmix_pkg;

    // Sample and mix widths.
    localparam int SAMPLE_W  = 16;
    localparam int MIX_W     = SAMPLE_W + 1;
    localparam int COEF_W    = 16;

    // Gain coefficient is unsigned Q4.12; reset value is unity.
    localparam int                Q_FRAC_BITS = 12;
    localparam logic [COEF_W-1:0] GAIN_RESET  = 16'd4096;

    // Divisor of the product term is 2^15 - 1.
    localparam int                DIV_SHIFT   = 15;
    localparam logic [MIX_W-1:0]  DIV_ONE     = 17'd32767;
    localparam logic [MIX_W-1:0]  DIV_TWO     = 17'd65534;

    // Scaled magnitude limit and width of the scaled value.
    localparam int                    SCALED_W  = 22;
    localparam logic signed [21:0]    MAG_LIMIT = 22'sd32767;

    // Decay to 95 percent: floor(c * 95 / 100) = (c * DECAY_RECIP) >> DECAY_SHIFT,
    // with DECAY_RECIP = 95 * ceil(2^26 / 100).
    localparam int          DECAY_SHIFT = 26;
    localparam int          DECAY_W     = 26;
    localparam logic [25:0] DECAY_RECIP = 26'd63753455;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [1:0] {
        MIX_PLAIN,
        MIX_BOTH_POS,
        MIX_BOTH_NEG
    } mix_class_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_WRITE
    } back_state_t;

    // One queued request: the unscaled mix and its frame marker.
    typedef struct packed {
        logic signed [MIX_W-1:0] mix_val;
        logic                    last;
    } mix_entry_t;

endpackage

@@ hdl/pcmmix_front.sv @@
// Front end of the mixer: accepts sample pairs and forms the unscaled mix.
// Depends on pcmmix_pkg.

module pcmmix_front
    import pcmmix_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] base_sample,
    input  logic signed [SAMPLE_W-1:0] added_sample,
    input  logic                       frame_end,
    output logic                       push_valid,
    input  logic                       push_ready,
    output mix_entry_t                 push_entry
);

    logic                    f1_valid_reg;
    logic                    f1_valid_next;
    mix_class_t              class_reg;
    logic signed [MIX_W-1:0] sum_reg;
    logic [30:0]             prod_reg;
    logic                    last_reg;

    logic                    in_fire;
    logic signed [31:0]      product;
    mix_class_t              class_in;
    logic [SAMPLE_W-1:0]     quot_hi;
    logic [MIX_W-1:0]        corr_sum;
    logic [MIX_W-1:0]        quot;
    logic [MIX_W:0]          mix_wide;

    assign in_ready = !f1_valid_reg || push_ready;
    assign in_fire  = in_valid && in_ready;
    assign product  = base_sample * added_sample;

    always_comb
    begin
        if (base_sample == '0 || added_sample == '0)
        begin
            class_in = MIX_PLAIN;
        end
        else if (!base_sample[SAMPLE_W-1] && !added_sample[SAMPLE_W-1])
        begin
            class_in = MIX_BOTH_POS;
        end
        else if (base_sample[SAMPLE_W-1] && added_sample[SAMPLE_W-1])
        begin
            class_in = MIX_BOTH_NEG;
        end
        else
        begin
            class_in = MIX_PLAIN;
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            f1_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            f1_valid_next = 1'b0;
        end
        else
        begin
            f1_valid_next = f1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            class_reg <= class_in;
            sum_reg   <= MIX_W'(base_sample) + MIX_W'(added_sample);
            prod_reg  <= product[30:0];
            last_reg  <= frame_end;
        end
    end

    // The product is positive and at most 2^30 when it is used. Writing it as
    // x * 2^15 + r gives p / 32767 = x + (x + r) / 32767, and x + r stays
    // below three times the divisor.
    always_comb
    begin
        quot_hi  = prod_reg[30:DIV_SHIFT];
        corr_sum = {1'b0, quot_hi} + {2'b00, prod_reg[DIV_SHIFT-1:0]};
        if (corr_sum >= DIV_TWO)
        begin
            quot = {1'b0, quot_hi} + 17'd2;
        end
        else if (corr_sum >= DIV_ONE)
        begin
            quot = {1'b0, quot_hi} + 17'd1;
        end
        else
        begin
            quot = {1'b0, quot_hi};
        end

        unique case (class_reg)
            MIX_BOTH_POS: mix_wide = {sum_reg[MIX_W-1], sum_reg} - {1'b0, quot};
            MIX_BOTH_NEG: mix_wide = {sum_reg[MIX_W-1], sum_reg} + {1'b0, quot};
            default:      mix_wide = {sum_reg[MIX_W-1], sum_reg};
        endcase
    end

    assign push_valid         = f1_valid_reg;
    assign push_entry.mix_val = mix_wide[MIX_W-1:0];
    assign push_entry.last    = last_reg;

endmodule

@@ hdl/pcmmix_queue.sv @@
// Short request queue between the mixer's front and back ends.
// Depends on pcmmix_pkg.

module pcmmix_queue
    import pcmmix_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  mix_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output mix_entry_t pop_entry
);

    mix_entry_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push_fire;
    logic                   pop_fire;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_entry  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push_fire, pop_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hdl/pcmmix_back.sv @@
// Back end of the mixer: gain scaling, overflow test, coefficient decay
// and the output register. Depends on pcmmix_pkg.

module pcmmix_back
    import pcmmix_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  mix_entry_t                 pop_entry,
    input  logic                       cfg_valid,
    input  logic [COEF_W-1:0]          initial_gain,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] mixed_sample,
    output logic                       gain_reduced,
    output logic                       frame_last
);

    localparam int PROD_W  = MIX_W + COEF_W + 1;
    localparam int DFULL_W = COEF_W + DECAY_W;

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [COEF_W-1:0]         coef_reg;
    logic [COEF_W-1:0]         coef_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [MIX_W-1:0]   val_reg;
    logic                      last_reg;
    logic signed [PROD_W-1:0]  scaled_prod_reg;
    logic [COEF_W-1:0]         decay_reg;
    logic [SAMPLE_W-1:0]       out_sample_reg;
    logic                      out_reduced_reg;
    logic                      out_last_reg;

    logic                      pop_fire;
    logic                      write_fire;
    logic signed [PROD_W-1:0]  scaled_prod;
    logic [DFULL_W-1:0]        decay_full;
    logic signed [PROD_W-1:0]  round_adj;
    logic signed [SCALED_W-1:0] scaled;
    logic                      bypass;
    logic                      overflow;
    logic                      reduce;
    logic [SAMPLE_W-1:0]       result_sample;

    assign scaled_prod = PROD_W'(val_reg) * $signed({1'b0, coef_reg});
    assign decay_full  = {{DECAY_W{1'b0}}, coef_reg} * {{COEF_W{1'b0}}, DECAY_RECIP};

    // Truncation toward zero: bias negative products before the shift.
    always_comb
    begin
        round_adj = scaled_prod_reg +
                    (scaled_prod_reg[PROD_W-1] ? PROD_W'((1 << Q_FRAC_BITS) - 1) : '0);
        scaled    = round_adj[Q_FRAC_BITS +: SCALED_W];
        bypass    = coef_reg == '0;
        overflow  = (scaled > MAG_LIMIT) || (scaled < -MAG_LIMIT);
        reduce    = !bypass && overflow;
        result_sample = bypass ? val_reg[SAMPLE_W-1:0] : scaled[SAMPLE_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        write_fire = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_WRITE;
            end
            BK_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    write_fire = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            coef_next = initial_gain;
        end
        else if (write_fire && reduce)
        begin
            coef_next = decay_reg;
        end
        else
        begin
            coef_next = coef_reg;
        end

        if (write_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign pop_fire = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            coef_reg      <= GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            coef_reg      <= coef_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            val_reg  <= pop_entry.mix_val;
            last_reg <= pop_entry.last;
        end
        if (state_reg == BK_MUL)
        begin
            scaled_prod_reg <= scaled_prod;
            decay_reg       <= decay_full[DECAY_SHIFT +: COEF_W];
        end
        if (write_fire)
        begin
            out_sample_reg  <= result_sample;
            out_reduced_reg <= reduce;
            out_last_reg    <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = out_sample_reg;
    assign gain_reduced = out_reduced_reg;
    assign frame_last   = out_last_reg;

endmodule

@@ hdl/pcm16_two_stream_mixer_unit.sv @@
// Top level of the two-stream PCM16 mixer: front end, request queue, back end.
// Depends on pcmmix_pkg, pcmmix_front, pcmmix_queue and pcmmix_back.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ---------------------------------------------
//   input     in_valid / in_ready    base_sample, added_sample, frame_end
//   output    out_valid / out_ready  mixed_sample, gain_reduced, frame_last
//   config    cfg_valid / cfg_ready  initial_gain (loads the gain coefficient)
//
// An accepted request passes the front register, the queue and then the
// back end, which handles one request at a time (take from queue, multiply,
// write result) and takes no new one until the last is written, because the
// gain coefficient that one request may reduce is needed by the next one.
// Reset empties the pipeline and sets the coefficient to unity (4096 in
// Q4.12). A stalled output holds its result, the back end waits, the
// two-entry queue fills and then in_ready drops.
//
// The front end registers the sum, the product and the sign class of the two
// samples, then divides the product by 32767 with a shift and a small
// correction and forms the unscaled mix, which it pushes into the queue.
// The back end multiplies the mix by the coefficient, truncates toward zero,
// and, when the scaled magnitude exceeds 32767, lowers the coefficient to
// 95 percent for the requests that follow. A zero coefficient bypasses the
// scaling entirely. The configuration port is always ready and is meant to be
// used only while the mixer is idle.

module pcm16_two_stream_mixer_unit
    import pcmmix_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] base_sample,
    input  logic signed [SAMPLE_W-1:0] added_sample,
    input  logic                       frame_end,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] mixed_sample,
    output logic                       gain_reduced,
    output logic                       frame_last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [COEF_W-1:0]          initial_gain
);

    logic       push_valid;
    logic       push_ready;
    mix_entry_t push_entry;
    logic       pop_valid;
    logic       pop_ready;
    mix_entry_t pop_entry;

    // The coefficient register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    pcmmix_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_sample  (base_sample),
        .added_sample (added_sample),
        .frame_end    (frame_end),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    pcmmix_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    pcmmix_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .cfg_valid    (cfg_valid && cfg_ready),
        .initial_gain (initial_gain),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_sample (mixed_sample),
        .gain_reduced (gain_reduced),
        .frame_last   (frame_last)
    );

endmodule

@@ hdl/pcmmix_checker.sv @@
// Port-level checker for the two-stream PCM16 mixer, bound to the top level.
// Depends on pcmmix_pkg and pcm16_two_stream_mixer_unit.

module pcmmix_checker
    import pcmmix_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] mixed_sample,
    input logic                       gain_reduced,
    input logic                       frame_last
);

    // Front register, queue entries, back end register and output register.
    localparam int          CAPACITY = QUEUE_DEPTH + 3;
    localparam int          CNT_W    = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;
    logic             in_fire;
    logic             out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        case ({in_fire, out_fire})
            2'b10:   pending_next = pending_reg + 1'b1;
            2'b01:   pending_next = pending_reg - 1'b1;
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A result is never shown without a request in flight.
    a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result shown with no request in flight");

    // The pipeline never holds more requests than it has places for.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(CAPACITY))
        else $error("more requests in flight than pipeline places");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(mixed_sample) && $stable(gain_reduced) && $stable(frame_last))
        else $error("stalled result changed");

endmodule

bind pcm16_two_stream_mixer_unit pcmmix_checker u_pcmmix_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mixed_sample (mixed_sample),
    .gain_reduced (gain_reduced),
    .frame_last   (frame_last)
);

@@ dv/pcmmix_mix_checker.sv @@
`timescale 1ns / 100ps
// Mix checker for the two-stream PCM16 mixer: watches the request, result and
// gain-write channels, predicts every result and compares it field by field.
// Depends on pcmmix_pkg for the widths, the reset gain and the mix classes.

module pcmmix_mix_checker
    import pcmmix_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] base_sample,
    input  logic signed [SAMPLE_W-1:0] added_sample,
    input  logic                       frame_end,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SAMPLE_W-1:0] mixed_sample,
    input  logic                       gain_reduced,
    input  logic                       frame_last,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [COEF_W-1:0]          initial_gain,
    output int                         pending,
    output int                         mismatch_count
);

    localparam longint PRODUCT_DIV = 32767;
    localparam longint UNITY_GAIN  = 4096;
    localparam longint PEAK_LIMIT  = 32767;
    localparam int     DECAY_NUM   = 95;
    localparam int     DECAY_DEN   = 100;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       reduced;
        logic                       last;
    } mix_result_t;

    logic [COEF_W-1:0] gain_coef;
    mix_result_t       expected_mixes[$];

    initial begin
        mismatch_count = 0;
        pending        = 0;
        gain_coef      = GAIN_RESET;
    end

    // Works out one result and applies the gain decay it causes.
    function automatic mix_result_t predict_mix(logic signed [SAMPLE_W-1:0] a,
                                                logic signed [SAMPLE_W-1:0] b,
                                                logic last);
        mix_class_t  cls;
        longint      sum;
        longint      prod;
        longint      mix;
        longint      gain_l;
        longint      scaled;
        longint      mag;
        int          coef_i;
        mix_result_t res;
        sum  = longint'(a) + longint'(b);
        prod = longint'(a) * longint'(b);
        if (a > 0 && b > 0)
            cls = MIX_BOTH_POS;
        else if (a < 0 && b < 0)
            cls = MIX_BOTH_NEG;
        else
            cls = MIX_PLAIN;
        case (cls)
            MIX_BOTH_POS: mix = sum - prod / PRODUCT_DIV;
            MIX_BOTH_NEG: mix = sum + prod / PRODUCT_DIV;
            default:      mix = sum;
        endcase
        res.reduced = 1'b0;
        if (gain_coef != '0)
        begin
            gain_l = gain_coef;
            scaled = (mix * gain_l) / UNITY_GAIN;
            mag    = (scaled < 0) ? -scaled : scaled;
            if (mag > PEAK_LIMIT)
            begin
                coef_i      = gain_coef;
                gain_coef   = COEF_W'(coef_i * DECAY_NUM / DECAY_DEN);
                res.reduced = 1'b1;
            end
            mix = scaled;
        end
        res.sample = mix[SAMPLE_W-1:0];
        res.last   = last;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        mix_result_t want;
        if (!rst_n)
        begin
            gain_coef = GAIN_RESET;
            expected_mixes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gain_coef = initial_gain;
            if (in_valid && in_ready)
                expected_mixes.push_back(predict_mix(base_sample, added_sample, frame_end));
            if (out_valid && out_ready)
            begin
                if (expected_mixes.size() == 0)
                    report_mismatch("unexpected result", mixed_sample, 0);
                else
                begin
                    want = expected_mixes.pop_front();
                    if (mixed_sample !== want.sample)
                        report_mismatch("mixed_sample", mixed_sample, want.sample);
                    if (gain_reduced !== want.reduced)
                        report_mismatch("gain_reduced", gain_reduced, want.reduced);
                    if (frame_last !== want.last)
                        report_mismatch("frame_last", frame_last, want.last);
                end
            end
        end
        pending = expected_mixes.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the two-stream PCM16 mixer: clock, reset, request and
// gain-write stimulus, output back-pressure, watchdog and the final verdict.
// Depends on pcmmix_pkg, pcm16_two_stream_mixer_unit and pcmmix_mix_checker.

module tb_top
    import pcmmix_pkg::*;
();

    // Random requests per gain setting, and the share of cycles in which
    // each side holds off while idling is enabled.
    localparam int PHASE_ITEMS    = 240;
    localparam int IDLE_PCT       = 16;
    localparam int NUM_PHASES     = 8;
    // Settle time after draining, so that the back end is surely idle.
    localparam int SETTLE_CYCLES  = 16;
    // Cycles without any accepted request, result or gain write.
    localparam int WATCHDOG_LIMIT = 2000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] base_sample;
    logic signed [SAMPLE_W-1:0] added_sample;
    logic                       frame_end;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       gain_reduced;
    logic                       frame_last;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [COEF_W-1:0]          initial_gain;

    int pending;
    int mismatch_count;
    int idle_pct       = IDLE_PCT;
    int stall_pct      = IDLE_PCT;
    int quiet_cycles   = 0;

    pcm16_two_stream_mixer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_sample  (base_sample),
        .added_sample (added_sample),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_sample (mixed_sample),
        .gain_reduced (gain_reduced),
        .frame_last   (frame_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .initial_gain (initial_gain)
    );

    // The checker sees exactly what the mixer sees and reports back how many
    // results are still owed and how many mismatches it found.
    pcmmix_mix_checker u_mix_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .base_sample    (base_sample),
        .added_sample   (added_sample),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mixed_sample   (mixed_sample),
        .gain_reduced   (gain_reduced),
        .frame_last     (frame_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .initial_gain   (initial_gain),
        .pending        (pending),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random; a stall percentage of zero gives a
    // stretch in which every result is taken at once.
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // The watchdog restarts on any handshake. A result that never comes, or
    // a channel that hangs, ends the run here.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Presents one request from the next falling edge on, possibly after
    // idle cycles with junk on the payload, and returns at the rising
    // edge where it is taken. Valid stays high between back-to-back requests.
    task automatic send_mix(logic signed [SAMPLE_W-1:0] a,
                            logic signed [SAMPLE_W-1:0] b,
                            logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid     <= 1'b0;
            base_sample  <= SAMPLE_W'($urandom);
            added_sample <= SAMPLE_W'($urandom);
            frame_end    <= 1'($urandom);
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        base_sample  <= a;
        added_sample <= b;
        frame_end    <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    // Loads the gain coefficient. Only called once the mixer is drained.
    task automatic write_gain(logic [COEF_W-1:0] gain);
        @(negedge clk);
        cfg_valid    <= 1'b1;
        initial_gain <= gain;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid    <= 1'b0;
        initial_gain <= COEF_W'($urandom);
    endtask

    // Stops sending, waits for every owed result, then lets the pipeline
    // settle so that the back end is surely idle.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Samples lean toward zero, the rails and large values of either sign,
    // so that both same-sign branches and the overflow path get plenty of
    // traffic; the rest are uniform over all 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 9))
            0: s = '0;
            1: s = 16'sh7FFF;
            2: s = 16'sh8000;
            3:
            begin
                s = SAMPLE_W'($urandom_range(1, 16));
                if ($urandom_range(0, 1) == 1)
                    s = -s;
            end
            4: s = SAMPLE_W'($urandom_range(24000, 32767));
            5: s = -SAMPLE_W'($urandom_range(24000, 32768));
            default: s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    initial
    begin
        logic [COEF_W-1:0] phase_gains [NUM_PHASES];
        int                phase;
        int                n;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        base_sample  = '0;
        added_sample = '0;
        frame_end    = 1'b0;
        cfg_valid    = 1'b0;
        initial_gain = GAIN_RESET;
        out_ready    = 1'b0;

        // Gain settings: bypass, the largest value (which decays over many
        // requests), the smallest nonzero value, 2.0, a random boost, unity,
        // a fully random value and a fixed boost of 12000.
        phase_gains[0] = '0;
        phase_gains[1] = 16'hFFFF;
        phase_gains[2] = 16'd1;
        phase_gains[3] = 16'd8192;
        phase_gains[4] = COEF_W'($urandom_range(4097, 65535));
        phase_gains[5] = GAIN_RESET;
        phase_gains[6] = COEF_W'($urandom);
        phase_gains[7] = 16'd12000;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests at the reset gain: zero operands, the rails,
        // mixed signs, both positive and both negative, and the frame marker.
        send_mix(16'sd0, 16'sd0, 1'b0);
        send_mix(16'sd0, 16'sh7FFF, 1'b1);
        send_mix(16'sh8000, 16'sd0, 1'b0);
        send_mix(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_mix(16'sh8000, 16'sh8000, 1'b1);
        send_mix(16'sh7FFF, 16'sh8000, 1'b0);
        send_mix(16'sh8000, 16'sh7FFF, 1'b0);
        send_mix(16'sd1, 16'sd1, 1'b0);
        send_mix(-16'sd1, -16'sd1, 1'b1);
        send_mix(16'sd1, -16'sd1, 1'b0);
        send_mix(-16'sd1, 16'sd1, 1'b0);
        send_mix(16'sh7FFF, 16'sd1, 1'b0);
        send_mix(16'sh8000, -16'sd1, 1'b0);
        send_mix(16'sd16384, 16'sd16384, 1'b0);
        send_mix(-16'sd16384, -16'sd16384, 1'b1);
        send_mix(16'sd12345, -16'sd23456, 1'b0);
        send_mix(-16'sd32767, -16'sd32767, 1'b0);
        send_mix(16'sd32766, 16'sh7FFF, 1'b1);
        wait_drained();

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_gain(phase_gains[phase]);
            // One whole phase runs with no idling on either side.
            idle_pct  = (phase == 3) ? 0 : IDLE_PCT;
            stall_pct = (phase == 3) ? 0 : IDLE_PCT;

            // The rails first, so every gain meets the largest mixes.
            send_mix(16'sh7FFF, 16'sh7FFF, 1'b0);
            send_mix(16'sh8000, 16'sh8000, 1'b1);
            send_mix(16'sh7FFF, 16'sh8000, 1'b0);
            send_mix(16'sd0, 16'sd0, 1'b0);

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_mix(rand_sample(), rand_sample(), $urandom_range(0, 7) == 0);
                // Once in the run the sender holds off until all is delivered.
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    wait_drained();
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
